/* hw/rtl/assert_macros.svh */
// Assertion macros for the RTL of the postfix evaluator, included by postfix_stack_evaluator_top.
// Each macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr holds on every clock edge
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// cons holds on the same edge as ante
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// cons holds on the edge after ante
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/pse_pkg.sv */
// Package for the postfix evaluator: sizes, character and status codes, beat types.
// No dependencies.
package pse_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int FRAC_BITS   = 16;

  localparam int DATA_W = 32;
  localparam int PROD_W = 2 * DATA_W;
  localparam int SP_W   = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int DVD_W  = DATA_W + FRAC_BITS;
  localparam int SQX_W  = DATA_W - 1 + FRAC_BITS;
  localparam int SQ_W   = SQX_W + (SQX_W % 2);
  localparam int ROOT_W = SQ_W / 2;
  localparam int CNT_W  = $clog2(DVD_W + 1);
  localparam int DIG_W  = 4 + FRAC_BITS;

  localparam logic [7:0] CH_ADD  = 8'h2B;
  localparam logic [7:0] CH_SUB  = 8'h2D;
  localparam logic [7:0] CH_MUL  = 8'h2A;
  localparam logic [7:0] CH_DIV  = 8'h2F;
  localparam logic [7:0] CH_ROOT = 8'h24;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_UNDERFLOW = 3'd1;
  localparam logic [2:0] ST_OVERFLOW  = 3'd2;
  localparam logic [2:0] ST_DIVZERO   = 3'd3;
  localparam logic [2:0] ST_NEGROOT   = 3'd4;
  localparam logic [2:0] ST_EMPTY     = 3'd5;
  localparam logic [2:0] ST_SATURATED = 3'd6;

  localparam logic [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_expression;
  } pse_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [2:0]               status;
  } pse_res_t;

endpackage

/* hw/rtl/pse_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies; contents are undefined until written.
module pse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/postfix_stack_evaluator_top.sv */
// Postfix evaluator over a STACK_DEPTH-deep signed fixed-point operand stack (pse_pkg, pse_ram).
// One character per beat. A digit or an ignored character passes through decode and finish;
// + - * also run 32 serial bit steps, / runs in the restoring divider and $ in the root
// unit, each followed by a write-back. The result beat is registered in the finish state,
// which holds while an earlier result is stalled; the next character is taken while that beat waits.
// rst (synchronous) empties the stack and clears the error; the stack RAM is not cleared.
`include "assert_macros.svh"

module postfix_stack_evaluator_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  pse_pkg::pse_item_t  item,
  output logic                res_valid,
  input  logic                res_stall,
  output pse_pkg::pse_res_t   res
);
  import pse_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_SQRT = 3'd5;
  localparam logic [2:0] S_WB   = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  function automatic logic [2:0] flag(input logic [2:0] cur, input logic [2:0] code);
    return (cur == ST_OK) ? code : cur;
  endfunction

  logic [2:0]        state, state_next;
  logic [SP_W-1:0]   sp, sp_next;
  logic [2:0]        err, err_next;
  logic [DATA_W-1:0] top, top_next;
  logic [7:0]        chr;
  logic              last;
  logic [CNT_W-1:0]  cnt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] rd_addr;
  logic [DATA_W-1:0] rdata;

  logic              neg;
  logic [DATA_W-1:0] mag_a_r, mag_b_r;
  logic [DATA_W-1:0] sa, sb, sr;
  logic              carry, a_sign, b_sign;
  logic [PROD_W-1:0] prod;
  logic [DVD_W-1:0]  quot;
  logic [DATA_W-1:0] drem;
  logic [SQ_W-1:0]   sq_x;
  logic [ROOT_W-1:0] sq_rem, sq_root;

  logic [SP_W-1:0]   sp_m1, sp_m2;
  logic              is_digit;
  logic [3:0]        dig;
  logic [DIG_W-1:0]  dig_wide;
  logic [PROD_W-1:0] dig_ext;
  logic              dig_sat;
  logic [DATA_W-1:0] dig_val;
  logic [DATA_W-1:0] mag_a, mag_b;
  logic              add_bit, add_carry;
  logic [DATA_W:0]   mul_sum;
  logic [DATA_W:0]   div_shift, div_diff;
  logic              div_ge;
  logic [ROOT_W+1:0] sq_sh, sq_trial;
  logic [ROOT_W+2:0] sq_diff;
  logic              sq_ge;
  logic [PROD_W-1:0] wq;
  logic              wq_hi_nz, wq_lo_nz;
  logic              wb_sat;
  logic [DATA_W-1:0] wb_val;
  logic              res_load;

  pse_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign item_stall = (state != S_IDLE);

  assign sp_m1   = sp - SP_W'(1);
  assign sp_m2   = sp - SP_W'(2);
  assign rd_addr = ADDR_W'(sp_m2);

  assign is_digit = (chr >= CH_ZERO) && (chr <= CH_NINE);
  assign dig      = 4'(chr - CH_ZERO);
  assign dig_wide = DIG_W'(dig) << FRAC_BITS;
  assign dig_ext  = PROD_W'(dig_wide);
  assign dig_sat  = |dig_ext[PROD_W-1:DATA_W-1];
  assign dig_val  = dig_sat ? VAL_MAX : dig_ext[DATA_W-1:0];

  assign mag_a = rdata[DATA_W-1] ? (~rdata + 1'b1) : rdata;
  assign mag_b = top[DATA_W-1] ? (~top + 1'b1) : top;

  // serial datapath steps
  assign add_bit   = sa[0] ^ sb[0] ^ carry;
  assign add_carry = (sa[0] & sb[0]) | (sa[0] & carry) | (sb[0] & carry);
  assign mul_sum   = {1'b0, prod[PROD_W-1:DATA_W]} + {1'b0, (prod[0] ? mag_a_r : '0)};
  assign div_shift = {drem, quot[DVD_W-1]};
  assign div_diff  = div_shift - {1'b0, mag_b_r};
  assign div_ge    = !div_diff[DATA_W];
  assign sq_sh     = {sq_rem, sq_x[SQ_W-1 -: 2]};
  assign sq_trial  = {sq_root, 2'b01};
  assign sq_diff   = {1'b0, sq_sh} - {1'b0, sq_trial};
  assign sq_ge     = !sq_diff[ROOT_W+2];

  // write-back: sign, saturation
  assign wq       = (chr == CH_MUL) ? (prod >> FRAC_BITS) : PROD_W'(quot);
  assign wq_hi_nz = |wq[PROD_W-1:DATA_W];
  assign wq_lo_nz = |wq[DATA_W-2:0];

  always_comb begin
    wb_sat = 1'b0;
    wb_val = sr;
    case (chr) inside
      CH_ADD, CH_SUB: begin
        wb_sat = (a_sign == b_sign) && (sr[DATA_W-1] != a_sign);
        wb_val = wb_sat ? (a_sign ? VAL_MIN : VAL_MAX) : sr;
      end
      CH_ROOT: begin
        wb_val = DATA_W'(sq_root);
      end
      default: begin
        if (!neg) begin
          wb_sat = wq_hi_nz || wq[DATA_W-1];
          wb_val = wb_sat ? VAL_MAX : wq[DATA_W-1:0];
        end else begin
          wb_sat = wq_hi_nz || (wq[DATA_W-1] && wq_lo_nz);
          wb_val = wb_sat ? VAL_MIN : (~wq[DATA_W-1:0] + 1'b1);
        end
      end
    endcase
  end

  always_comb begin
    state_next = state;
    sp_next    = sp;
    err_next   = err;
    top_next   = top;
    ram_we     = 1'b0;
    ram_waddr  = ADDR_W'(sp);
    ram_wdata  = top;
    res_load   = 1'b0;
    unique case (state) inside
      S_IDLE: begin
        if (item_valid) begin
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        state_next = S_FIN;
        if (is_digit) begin
          if (dig_sat) begin
            err_next = flag(err_next, ST_SATURATED);
          end
          if (sp >= SP_W'(STACK_DEPTH)) begin
            err_next = flag(err_next, ST_OVERFLOW);
          end else begin
            ram_we    = 1'b1;
            ram_waddr = ADDR_W'(sp);
            ram_wdata = dig_val;
            top_next  = dig_val;
            sp_next   = sp + SP_W'(1);
          end
        end else if (chr inside {CH_ADD, CH_SUB, CH_MUL, CH_DIV}) begin
          if (sp < SP_W'(2)) begin
            err_next = flag(err, ST_UNDERFLOW);
          end else if ((chr == CH_DIV) && (top == '0)) begin
            err_next  = flag(err, ST_DIVZERO);
            ram_we    = 1'b1;
            ram_waddr = ADDR_W'(sp_m2);
            ram_wdata = '0;
            top_next  = '0;
            sp_next   = sp_m1;
          end else if (chr == CH_MUL) begin
            state_next = S_MUL;
          end else if (chr == CH_DIV) begin
            state_next = S_DIV;
          end else begin
            state_next = S_ADD;
          end
        end else if (chr == CH_ROOT) begin
          if (sp == '0) begin
            err_next = flag(err, ST_UNDERFLOW);
          end else if (top[DATA_W-1]) begin
            err_next  = flag(err, ST_NEGROOT);
            ram_we    = 1'b1;
            ram_waddr = ADDR_W'(sp_m1);
            ram_wdata = '0;
            top_next  = '0;
          end else begin
            state_next = S_SQRT;
          end
        end
      end
      S_ADD, S_MUL, S_DIV, S_SQRT: begin
        if (cnt == CNT_W'(1)) begin
          state_next = S_WB;
        end
      end
      S_WB: begin
        state_next = S_FIN;
        if (wb_sat) begin
          err_next = flag(err, ST_SATURATED);
        end
        ram_we    = 1'b1;
        ram_wdata = wb_val;
        top_next  = wb_val;
        if (chr == CH_ROOT) begin
          ram_waddr = ADDR_W'(sp_m1);
        end else begin
          ram_waddr = ADDR_W'(sp_m2);
          sp_next   = sp_m1;
        end
      end
      S_FIN: begin
        if (!last) begin
          state_next = S_IDLE;
        end else if (!res_valid || !res_stall) begin
          res_load   = 1'b1;
          sp_next    = '0;
          err_next   = ST_OK;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sp        <= '0;
      err       <= ST_OK;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      sp    <= sp_next;
      err   <= err_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    top <= top_next;
    if (res_load) begin
      res.value  <= (sp == '0) ? '0 : top;
      res.status <= (err != ST_OK) ? err : ((sp == '0) ? ST_EMPTY : ST_OK);
    end
    if ((state == S_IDLE) && item_valid) begin
      chr  <= item.char_code;
      last <= item.end_of_expression;
    end
    unique case (state) inside
      S_DEC: begin
        if (chr == CH_DIV) begin
          cnt <= CNT_W'(DVD_W);
        end else if (chr == CH_ROOT) begin
          cnt <= CNT_W'(ROOT_W);
        end else begin
          cnt <= CNT_W'(DATA_W);
        end
        neg     <= rdata[DATA_W-1] ^ top[DATA_W-1];
        mag_a_r <= mag_a;
        mag_b_r <= mag_b;
        sa      <= rdata;
        sb      <= (chr == CH_SUB) ? ~top : top;
        carry   <= (chr == CH_SUB);
        a_sign  <= rdata[DATA_W-1];
        b_sign  <= top[DATA_W-1] ^ (chr == CH_SUB);
        prod    <= {{DATA_W{1'b0}}, mag_b};
        quot    <= DVD_W'(mag_a) << FRAC_BITS;
        drem    <= '0;
        sq_x    <= SQ_W'(top[DATA_W-2:0]) << FRAC_BITS;
        sq_rem  <= '0;
        sq_root <= '0;
      end
      S_ADD: begin
        cnt   <= cnt - CNT_W'(1);
        sa    <= sa >> 1;
        sb    <= sb >> 1;
        sr    <= {add_bit, sr[DATA_W-1:1]};
        carry <= add_carry;
      end
      S_MUL: begin
        cnt  <= cnt - CNT_W'(1);
        prod <= {mul_sum, prod[DATA_W-1:1]};
      end
      S_DIV: begin
        cnt  <= cnt - CNT_W'(1);
        drem <= div_ge ? div_diff[DATA_W-1:0] : div_shift[DATA_W-1:0];
        quot <= {quot[DVD_W-2:0], div_ge};
      end
      S_SQRT: begin
        cnt     <= cnt - CNT_W'(1);
        sq_rem  <= sq_ge ? ROOT_W'(sq_diff) : ROOT_W'(sq_sh);
        sq_root <= {sq_root[ROOT_W-2:0], sq_ge};
        sq_x    <= sq_x << 2;
      end
      default: begin
      end
    endcase
  end

  `ASSERT_ALWAYS(a_sp_bound, sp <= SP_W'(STACK_DEPTH), "stack pointer beyond depth")
  `ASSERT_IMPLIES(a_cnt_live, state == S_ADD || state == S_MUL || state == S_DIV || state == S_SQRT, cnt != '0, "serial unit running with zero count")
  `ASSERT_IMPLIES(a_empty_zero, res_valid && res.status == ST_EMPTY, res.value == '0, "empty result with nonzero value")
  `ASSERT_NEXT(a_err_sticky, err != ST_OK && state != S_FIN, err == $past(err), "sticky error changed")
  `ASSERT_IMPLIES(a_emit_clear, $rose(res_valid), sp == '0 && err == ST_OK, "state not cleared after result")

endmodule
